// File: hdl/rvcc_pkg.sv
// Package for the RV32I to RVC compressor: command and form codes, shared types.
`default_nettype none

package rvcc_pkg;

  // Decoded RV32I instruction selector as carried on the input channel.
  typedef enum logic [4:0] {
    CMD_ADD   = 5'd0,
    CMD_SUB   = 5'd1,
    CMD_AND   = 5'd2,
    CMD_OR    = 5'd3,
    CMD_XOR   = 5'd4,
    CMD_JALR  = 5'd5,
    CMD_ADDI  = 5'd6,
    CMD_SLLI  = 5'd7,
    CMD_LW    = 5'd8,
    CMD_SRLI  = 5'd9,
    CMD_SRAI  = 5'd10,
    CMD_ANDI  = 5'd11,
    CMD_SW    = 5'd12,
    CMD_BEQ   = 5'd13,
    CMD_BNE   = 5'd14,
    CMD_LUI   = 5'd15,
    CMD_JAL   = 5'd16,
    CMD_OTHER = 5'd17
  } rvcc_cmd_e;

  // Compressed form that was selected.
  typedef enum logic [4:0] {
    KIND_NONE   = 5'd0,
    KIND_ADD    = 5'd1,
    KIND_MV     = 5'd2,
    KIND_JR     = 5'd3,
    KIND_JALR   = 5'd4,
    KIND_LI     = 5'd5,
    KIND_LUI    = 5'd6,
    KIND_ADDI   = 5'd7,
    KIND_SLLI   = 5'd8,
    KIND_LW     = 5'd9,
    KIND_SW     = 5'd10,
    KIND_AND    = 5'd11,
    KIND_OR     = 5'd12,
    KIND_XOR    = 5'd13,
    KIND_SUB    = 5'd14,
    KIND_BEQZ   = 5'd15,
    KIND_BNEZ   = 5'd16,
    KIND_SRLI   = 5'd17,
    KIND_SRAI   = 5'd18,
    KIND_ANDI   = 5'd19,
    KIND_J      = 5'd20,
    KIND_JAL    = 5'd21
  } rvcc_kind_e;

  localparam logic [4:0] KIND_LAST = 5'd21;

  typedef struct packed {
    logic [4:0]  command;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
  } rvcc_instr_t;

  typedef struct packed {
    logic        compressible;
    rvcc_kind_e  kind;
    logic [15:0] halfword;
  } rvcc_result_t;

endpackage

`default_nettype wire

// File: hdl/rvcc_encode.sv
// Combinational RVC form selection and 16-bit encoding of one instruction.
`default_nettype none

module rvcc_encode
  import rvcc_pkg::*;
(
  input  rvcc_instr_t  instr_i,
  output rvcc_result_t result_o
);

  logic [4:0]  rd, rs1, rs2;
  logic [31:0] u;
  logic        rd_p, rs1_p, rs2_p;
  logic        imm_zero, imm_s6, imm_u5, imm_u7, imm_s9, imm_s12;
  logic        rd_eq_rs1;
  rvcc_kind_e  kind;
  logic [15:0] h;

  assign rd  = instr_i.dest_reg;
  assign rs1 = instr_i.src1_reg;
  assign rs2 = instr_i.src2_reg;
  assign u   = instr_i.immediate;

  // Compact registers are x8 to x15.
  assign rd_p  = (rd[4:3]  == 2'b01);
  assign rs1_p = (rs1[4:3] == 2'b01);
  assign rs2_p = (rs2[4:3] == 2'b01);
  assign rd_eq_rs1 = (rd == rs1);

  // Signed ranges hold when all bits above the field agree with its sign bit.
  assign imm_zero = (u == 32'd0);
  assign imm_s6   = (&u[31:5])  || (u[31:5]  == '0);
  assign imm_u5   = (u[31:5] == '0);
  assign imm_u7   = (u[31:7] == '0);
  assign imm_s9   = (&u[31:8])  || (u[31:8]  == '0);
  assign imm_s12  = (&u[31:11]) || (u[31:11] == '0);

  always_comb begin
    kind = KIND_NONE;
    h    = 16'h0000;
    unique case (instr_i.command) inside
      CMD_ADD: begin
        if (rd_eq_rs1 && rd != 5'd0 && rs2 != 5'd0) begin
          kind = KIND_ADD;
          h    = {4'b1001, rd, rs2, 2'b10};
        end else if (rs1 == 5'd0 && rd != 5'd0 && rs2 != 5'd0) begin
          kind = KIND_MV;
          h    = {4'b1000, rd, rs2, 2'b10};
        end
      end
      CMD_SUB, CMD_AND, CMD_OR, CMD_XOR: begin
        if (rd_eq_rs1 && rd_p && rs2_p) begin
          case (instr_i.command)
            CMD_SUB: begin
              kind = KIND_SUB;
              h    = {6'b100011, rd[2:0], 2'b00, rs2[2:0], 2'b01};
            end
            CMD_XOR: begin
              kind = KIND_XOR;
              h    = {6'b100011, rd[2:0], 2'b01, rs2[2:0], 2'b01};
            end
            CMD_OR: begin
              kind = KIND_OR;
              h    = {6'b100011, rd[2:0], 2'b10, rs2[2:0], 2'b01};
            end
            default: begin
              kind = KIND_AND;
              h    = {6'b100011, rd[2:0], 2'b11, rs2[2:0], 2'b01};
            end
          endcase
        end
      end
      CMD_JALR: begin
        if (imm_zero && rs1 != 5'd0) begin
          if (rd == 5'd0) begin
            kind = KIND_JR;
            h    = {4'b1000, rs1, 5'd0, 2'b10};
          end else if (rd == 5'd1) begin
            kind = KIND_JALR;
            h    = {4'b1001, rs1, 5'd0, 2'b10};
          end
        end
      end
      CMD_ADDI: begin
        if (rd != 5'd0 && rs1 == 5'd0 && imm_s6) begin
          kind = KIND_LI;
          h    = {3'b010, u[5], rd, u[4:0], 2'b01};
        end else if (rd_eq_rs1 && rd != 5'd0 && !imm_zero && imm_s6) begin
          kind = KIND_ADDI;
          h    = {3'b000, u[5], rd, u[4:0], 2'b01};
        end
      end
      CMD_SLLI: begin
        if (rd_eq_rs1 && rd != 5'd0 && imm_u5) begin
          kind = KIND_SLLI;
          h    = {4'b0000, rd, u[4:0], 2'b10};
        end
      end
      CMD_LW: begin
        if (imm_u7 && u[1:0] == 2'b00 && rs1_p && rd_p) begin
          kind = KIND_LW;
          h    = {3'b010, u[5:3], rs1[2:0], u[2], u[6], rd[2:0], 2'b00};
        end
      end
      CMD_SW: begin
        if (imm_u7 && u[1:0] == 2'b00 && rs1_p && rs2_p) begin
          kind = KIND_SW;
          h    = {3'b110, u[5:3], rs1[2:0], u[2], u[6], rs2[2:0], 2'b00};
        end
      end
      CMD_SRLI: begin
        if (rd_eq_rs1 && rd_p && imm_u5) begin
          kind = KIND_SRLI;
          h    = {4'b1000, 2'b00, rd[2:0], u[4:0], 2'b01};
        end
      end
      CMD_SRAI: begin
        if (rd_eq_rs1 && rd_p && imm_u5) begin
          kind = KIND_SRAI;
          h    = {4'b1000, 2'b01, rd[2:0], u[4:0], 2'b01};
        end
      end
      CMD_ANDI: begin
        if (rd_eq_rs1 && rd_p && imm_s6) begin
          kind = KIND_ANDI;
          h    = {3'b100, u[5], 2'b10, rd[2:0], u[4:0], 2'b01};
        end
      end
      CMD_BEQ: begin
        if (rs2 == 5'd0 && rs1_p && imm_s9) begin
          kind = KIND_BEQZ;
          h    = {3'b110, u[8], u[4:3], rs1[2:0], u[7:6], u[2:1], u[5], 2'b01};
        end
      end
      CMD_BNE: begin
        if (rs2 == 5'd0 && rs1_p && imm_s9) begin
          kind = KIND_BNEZ;
          h    = {3'b111, u[8], u[4:3], rs1[2:0], u[7:6], u[2:1], u[5], 2'b01};
        end
      end
      CMD_LUI: begin
        if (rd != 5'd0 && rd != 5'd2 && !imm_zero && imm_s6) begin
          kind = KIND_LUI;
          h    = {3'b011, u[5], rd, u[4:0], 2'b01};
        end
      end
      CMD_JAL: begin
        if (imm_s12) begin
          if (rd == 5'd0) begin
            kind = KIND_J;
            h    = {3'b101, u[11], u[4], u[9:8], u[10], u[6], u[7], u[3:1], u[5],
                    2'b01};
          end else if (rd == 5'd1) begin
            kind = KIND_JAL;
            h    = {3'b001, u[11], u[4], u[9:8], u[10], u[6], u[7], u[3:1], u[5],
                    2'b01};
          end
        end
      end
      default: begin
        kind = KIND_NONE;
        h    = 16'h0000;
      end
    endcase
  end

  assign result_o.compressible = (kind != KIND_NONE);
  assign result_o.kind         = kind;
  assign result_o.halfword     = h;

endmodule

`default_nettype wire

// File: hdl/rv32i_to_rvc_compressor_core.sv
// Top level of the RV32I to RVC compressor: input register, encoder, result register.
`default_nettype none

// Channel  Dir  tdata (low bit up)                               tuser (low bit up)
// s_axis   in   dest_reg[4:0] src1_reg[9:5] src2_reg[14:10]      command[4:0]
//               immediate[46:15], zero [47]
// m_axis   out  halfword[15:0]                                   compressible[0]
//                                                                compressed_kind[5:1]
//
// Each item passes through two registers: it is taken into the input register,
// encoded by the combinational form selector, and held in the result register.
// One item is accepted in every cycle while the output side keeps taking results.
// A stalled output holds its result; the input register still fills, so the
// block holds up to two items before it lowers s_axis_tready.
// Reset (rst_ni low, asynchronous) empties both registers; nothing else is cleared.

module rv32i_to_rvc_compressor_core
  import rvcc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items: tdata = dest_reg, src1_reg, src2_reg, immediate (lowest first)
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  // tuser = command
  input  wire logic [4:0]  s_axis_tuser,
  // Result items: tdata = halfword
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,
  // tuser = compressible, compressed_kind (lowest first)
  output      logic [5:0]  m_axis_tuser
);

  logic         in_valid_q, in_valid_d;
  rvcc_instr_t  in_instr_q;
  logic         out_valid_q, out_valid_d;
  rvcc_result_t out_res_q;
  rvcc_result_t enc_res;
  logic         in_ready, out_ready;

  // The result register can take a new value when it is empty or being drained;
  // the input register can take one when it is empty or moving forward.
  assign out_ready = !out_valid_q || m_axis_tready;
  assign in_ready  = !in_valid_q || out_ready;

  assign in_valid_d  = in_ready  ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = out_ready ? in_valid_q    : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; they are loaded only with a live item.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_ready) begin
      in_instr_q.command   <= s_axis_tuser;
      in_instr_q.dest_reg  <= s_axis_tdata[4:0];
      in_instr_q.src1_reg  <= s_axis_tdata[9:5];
      in_instr_q.src2_reg  <= s_axis_tdata[14:10];
      in_instr_q.immediate <= s_axis_tdata[46:15];
    end
  end

  rvcc_encode u_encode (
    .instr_i  (in_instr_q),
    .result_o (enc_res)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_q && out_ready) begin
      out_res_q <= enc_res;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.halfword;
  assign m_axis_tuser  = {out_res_q.kind, out_res_q.compressible};

endmodule

`default_nettype wire

// File: hdl/rvcc_checker.sv
// Port-level assertions for the compressor core and the bind that attaches them.
`default_nettype none

module rvcc_checker
  import rvcc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [5:0]  m_axis_tuser
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The flag agrees with the form code.
  a_flag_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[5:1] != 5'd0)))
    else $error("compressible flag disagrees with form code");

  // An instruction without a compressed form gives a zero halfword.
  a_zero_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'h0000)
    else $error("non-zero halfword for incompressible item");

  // Form codes stay within the defined set, and a compressed form is never
  // a 32-bit encoding (low bits 11).
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[5:1] <= KIND_LAST) &&
      (!m_axis_tuser[0] || m_axis_tdata[1:0] != 2'b11))
    else $error("invalid form code or encoding");

  // An item accepted into an empty block with a free output shows up on the
  // result port once it has passed the input register and the result register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid && m_axis_tready &&
      $past(s_axis_tready) && !$past(s_axis_tvalid) |-> ##2 m_axis_tvalid)
    else $error("result missing after accepted item");

endmodule

bind rv32i_to_rvc_compressor_core rvcc_checker u_rvcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
